// File: rtl/elevator_car_controller_unit_assert.svh
`ifndef ELEVATOR_CAR_CONTROLLER_UNIT_ASSERT_SVH
`define ELEVATOR_CAR_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ECCU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ECCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ecc_pkg.sv
package ecc_pkg;

    localparam int FLOORS   = 4;
    localparam int FLOOR_W  = 2;
    localparam int TICKS_W  = 20;

    localparam logic [TICKS_W-1:0] DOOR_TICKS_RESET = TICKS_W'(5000);

    typedef logic [FLOOR_W-1:0] t_floor;
    typedef logic [FLOORS-1:0]  t_floor_vec;

    typedef enum logic [1:0] {
        MODE_STARTUP = 2'd0,
        MODE_MOVE    = 2'd1,
        MODE_DOORS   = 2'd2,
        MODE_WAIT    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        MOTOR_OFF  = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2
    } t_motor;

    typedef enum logic {
        DIR_UP   = 1'b0,
        DIR_DOWN = 1'b1
    } t_dir;

    typedef struct packed {
        logic       at_floor;
        t_floor     sensor_floor;
        t_floor_vec cab_requests;
        t_floor_vec hall_up;
        t_floor_vec hall_down;
        t_floor_vec responsible;
    } t_in_item;

    typedef struct packed {
        logic [1:0] motor_dir;
        logic       door_lamp;
        t_floor     floor_indicator;
        logic       finished_valid;
        logic [1:0] mode;
    } t_out_item;

    typedef struct packed {
        t_mode               mode;
        t_dir                dir;
        t_floor              last_floor;
        logic [TICKS_W-1:0]  door_count;
    } t_car_state;

    // Any active floor strictly beyond cur in direction dir.
    function automatic logic any_ahead(t_floor_vec act, t_dir dir, t_floor cur);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < FLOORS; i++) begin
            if (dir == DIR_UP) begin
                if (i > int'(cur)) hit = hit | act[i];
            end else begin
                if (i < int'(cur)) hit = hit | act[i];
            end
        end
        return hit;
    endfunction

endpackage

// File: rtl/ecc_step.sv
module ecc_step (
    input  ecc_pkg::t_in_item              i_item,
    input  ecc_pkg::t_car_state            i_state,
    input  logic [ecc_pkg::TICKS_W-1:0]    i_door_ticks,
    output ecc_pkg::t_car_state            o_state,
    output ecc_pkg::t_out_item             o_result
);
    import ecc_pkg::*;

    logic       seen;
    t_floor     cur;
    t_floor_vec active;
    t_floor_vec same_calls;
    t_floor_vec other_calls;
    logic       ahead;
    logic       behind;
    logic       stop_here;
    logic [TICKS_W-1:0] cnt_next;
    t_motor     motor;
    logic       lamp;
    logic       done;

    assign seen   = i_item.at_floor && (int'(i_item.sensor_floor) < FLOORS);
    assign cur    = seen ? i_item.sensor_floor : i_state.last_floor;
    assign active = i_item.cab_requests
                  | (i_item.responsible & (i_item.hall_up | i_item.hall_down));

    assign ahead  = any_ahead(active, i_state.dir, cur);
    assign behind = any_ahead(active, t_dir'(~i_state.dir), cur);

    assign same_calls  = (i_state.dir == DIR_UP) ? i_item.hall_up : i_item.hall_down;
    assign other_calls = (i_state.dir == DIR_UP) ? i_item.hall_down : i_item.hall_up;

    // cab call always stops; hall call in travel direction, or the other way
    // when nothing remains ahead
    assign stop_here = i_item.cab_requests[cur]
                    || (i_item.responsible[cur]
                        && (same_calls[cur] || (!ahead && other_calls[cur])));

    always_comb begin
        o_state  = i_state;
        o_state.last_floor = cur;
        motor    = MOTOR_OFF;
        lamp     = 1'b0;
        done     = 1'b0;
        cnt_next = '0;
        unique case (i_state.mode)
            MODE_STARTUP: begin
                motor = MOTOR_UP;
                if (seen) begin
                    motor        = MOTOR_OFF;
                    o_state.mode = MODE_WAIT;
                end
            end
            MODE_WAIT: begin
                if (active[cur]) begin
                    o_state.mode       = MODE_DOORS;
                    o_state.door_count = '0;
                end else if (ahead) begin
                    o_state.mode = MODE_MOVE;
                end else if (behind) begin
                    o_state.dir  = t_dir'(~i_state.dir);
                    o_state.mode = MODE_MOVE;
                end
            end
            MODE_MOVE: begin
                motor = (i_state.dir == DIR_UP) ? MOTOR_UP : MOTOR_DOWN;
                if (seen && stop_here) begin
                    o_state.mode       = MODE_DOORS;
                    o_state.door_count = '0;
                end else if (!ahead) begin
                    motor        = MOTOR_OFF;
                    o_state.mode = MODE_WAIT;
                end
            end
            MODE_DOORS: begin
                lamp = 1'b1;
                if (i_state.door_count == '0) begin
                    // entry tick: a zero setting acts as one tick
                    done     = 1'b1;
                    cnt_next = (i_door_ticks == '0) ? '0 : i_door_ticks - 1'b1;
                end else begin
                    cnt_next = i_state.door_count - 1'b1;
                end
                o_state.door_count = cnt_next;
                if (cnt_next == '0) o_state.mode = MODE_WAIT;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    always_comb begin
        o_result.motor_dir       = motor;
        o_result.door_lamp       = lamp;
        o_result.floor_indicator = cur;
        o_result.finished_valid  = done;
        o_result.mode            = o_state.mode;
    end

endmodule

// File: rtl/elevator_car_controller_unit.sv
// Channel | Direction | Handshake                 | Payload
// in      | request   | i_in_valid / o_in_stall   | i_in  (ecc_pkg::t_in_item)
// out     | result    | o_out_valid / i_out_stall | o_out (ecc_pkg::t_out_item)
// cfg     | write     | i_cfg_we                  | i_cfg_wdata (door_open_ticks)
//
// One request per cycle sustained while the output is not stalled; each accepted request gives one result.
// The step logic sits between the input register and the output register.
// Synchronous active-low reset: mode startup, direction up, floor 0, door time 5000.
// A stalled output holds its result; the input register still takes a new request
// whenever the output register is empty or being drained in the same cycle.
module elevator_car_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ecc_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ecc_pkg::t_out_item            o_out,
    input  logic                          i_cfg_we,
    input  logic [ecc_pkg::TICKS_W-1:0]   i_cfg_wdata
);
    import ecc_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    t_car_state         r_state;
    t_car_state         n_state;
    t_out_item          n_out;
    logic [TICKS_W-1:0] r_door_ticks;
    logic               advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    ecc_step u_step (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_door_ticks (r_door_ticks),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) r_in <= i_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= MODE_STARTUP;
            r_state.dir        <= DIR_UP;
            r_state.last_floor <= '0;
            r_state.door_count <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_ticks <= DOOR_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_door_ticks <= i_cfg_wdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/ecc_checker.sv
`include "elevator_car_controller_unit_assert.svh"

module ecc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  ecc_pkg::t_out_item i_out
);
    import ecc_pkg::*;

    `ECCU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "stalled result changed")

    // served flag only comes with the door lamp on the entry tick
    `ECCU_ASSERT_NOW(a_done_lamp, i_clk, i_rst_n, i_out_valid && i_out.finished_valid, i_out.door_lamp, "served flag without door lamp")

    `ECCU_ASSERT_NOW(a_lamp_motor, i_clk, i_rst_n, i_out_valid && i_out.door_lamp, i_out.motor_dir == MOTOR_OFF && (i_out.mode == MODE_DOORS || i_out.mode == MODE_WAIT), "motor or mode wrong with doors open")

    `ECCU_ASSERT_NOW(a_startup_up, i_clk, i_rst_n, i_out_valid && i_out.mode == MODE_STARTUP, i_out.motor_dir == MOTOR_UP && !i_out.door_lamp, "startup without upward motor")

endmodule

bind elevator_car_controller_unit ecc_checker u_ecc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

// File: bench/tb_elevator_car_controller_unit.sv
`timescale 1ns / 1ps

module tb_elevator_car_controller_unit;
    import ecc_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    class car_scoreboard;
        t_mode              mode;
        t_dir               dir;
        t_floor             floor;
        logic [TICKS_W-1:0] door_left;
        logic [TICKS_W-1:0] door_ticks;
        t_out_item          due_q[$];
        int                 errors;

        function new();
            mode       = MODE_STARTUP;
            dir        = DIR_UP;
            floor      = '0;
            door_left  = '0;
            door_ticks = DOOR_TICKS_RESET;
            errors     = 0;
        endfunction

        // calls strictly past floor f in direction d
        function bit calls_beyond(t_floor_vec act, t_dir d, t_floor f);
            t_floor_vec under;
            t_floor_vec here;
            under = t_floor_vec'((1 << f) - 1);
            here  = t_floor_vec'(1) << f;
            if (d == DIR_UP)
                return (act & ~under & ~here) != '0;
            return (act & under) != '0;
        endfunction

        function bit stop_here(t_in_item req, t_floor_vec act);
            t_floor_vec here;
            t_floor_vec same;
            t_floor_vec other;
            here  = t_floor_vec'(1) << floor;
            same  = (dir == DIR_UP) ? req.hall_up : req.hall_down;
            other = (dir == DIR_UP) ? req.hall_down : req.hall_up;
            if ((req.cab_requests & here) != '0)
                return 1'b1;
            if ((req.responsible & here) != '0) begin
                if ((same & here) != '0)
                    return 1'b1;
                // opposite-direction call only when nothing lies further on
                if (!calls_beyond(act, dir, floor) && (other & here) != '0)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(t_in_item req);
            t_floor_vec act;
            t_motor     motor;
            logic       lamp;
            logic       served;
            logic       seen;
            t_out_item  want;
            act    = req.cab_requests | (req.responsible & (req.hall_up | req.hall_down));
            motor  = MOTOR_OFF;
            lamp   = 1'b0;
            served = 1'b0;
            seen   = req.at_floor && (int'(req.sensor_floor) < FLOORS);
            if (seen)
                floor = req.sensor_floor;
            case (mode)
                MODE_STARTUP: begin
                    if (seen)
                        mode = MODE_WAIT;
                    else
                        motor = MOTOR_UP;
                end
                MODE_WAIT: begin
                    if (act[floor]) begin
                        mode      = MODE_DOORS;
                        door_left = '0;
                    end else if (calls_beyond(act, dir, floor)) begin
                        mode = MODE_MOVE;
                    end else if (calls_beyond(act, (dir == DIR_UP) ? DIR_DOWN : DIR_UP,
                                              floor)) begin
                        dir  = (dir == DIR_UP) ? DIR_DOWN : DIR_UP;
                        mode = MODE_MOVE;
                    end
                end
                MODE_MOVE: begin
                    motor = (dir == DIR_UP) ? MOTOR_UP : MOTOR_DOWN;
                    if (seen && stop_here(req, act)) begin
                        mode      = MODE_DOORS;
                        door_left = '0;
                    end else if (!calls_beyond(act, dir, floor)) begin
                        motor = MOTOR_OFF;
                        mode  = MODE_WAIT;
                    end
                end
                default: begin
                    lamp = 1'b1;
                    if (door_left == '0) begin
                        served    = 1'b1;
                        door_left = (door_ticks == '0) ? '0 : door_ticks - 1'b1;
                    end else begin
                        door_left = door_left - 1'b1;
                    end
                    if (door_left == '0)
                        mode = MODE_WAIT;
                end
            endcase
            want.motor_dir       = motor;
            want.door_lamp       = lamp;
            want.floor_indicator = floor;
            want.finished_valid  = served;
            want.mode            = mode;
            due_q.push_back(want);
        endfunction

        function void compare(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_q.size() == 0) begin
                $error("result %h with no request pending", got);
                errors++;
                return;
            end
            want = due_q.pop_front();
            compare("motor_dir", want.motor_dir, got.motor_dir);
            compare("door_lamp", 2'(want.door_lamp), 2'(got.door_lamp));
            compare("floor_indicator", want.floor_indicator, got.floor_indicator);
            compare("finished_valid", 2'(want.finished_valid), 2'(got.finished_valid));
            compare("mode", want.mode, got.mode);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_in_item           in_req = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic [TICKS_W-1:0] cfg_wdata = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out;

    bit                 steady = 1'b0;
    int                 idle_cycles = 0;
    car_scoreboard      sb = new();

    // traffic state for the random requests
    t_floor             pos = '0;
    t_floor_vec         cab_r = '0;
    t_floor_vec         up_r = '0;
    t_floor_vec         dn_r = '0;
    t_floor_vec         resp_r = '0;

    elevator_car_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(99) < 10);
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall)
            sb.check_result(o_out);
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item mk(logic at, t_floor sf, t_floor_vec cab,
                                    t_floor_vec up, t_floor_vec dn, t_floor_vec resp);
        t_in_item r;
        r.at_floor     = at;
        r.sensor_floor = sf;
        r.cab_requests = cab;
        r.hall_up      = up;
        r.hall_down    = dn;
        r.responsible  = resp;
        return r;
    endfunction

    task automatic send_request(input t_in_item req);
        while (!steady && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (o_in_stall);
        sb.note_request(req);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_door_ticks(input logic [TICKS_W-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.door_ticks = ticks;
    endtask

    // mostly a plausible car ride: calls that linger, sensor walking floor by floor
    task automatic next_traffic(output t_in_item req);
        t_floor f;
        if ($urandom_range(99) < 10) begin
            req = t_in_item'($urandom);
            return;
        end
        if ($urandom_range(99) < 6) begin
            f = t_floor'($urandom_range(FLOORS - 1));
            cab_r[f] = 1'b1;
        end
        if ($urandom_range(99) < 6) begin
            f = t_floor'($urandom_range(FLOORS - 1));
            up_r[f] = 1'b1;
        end
        if ($urandom_range(99) < 6) begin
            f = t_floor'($urandom_range(FLOORS - 1));
            dn_r[f] = 1'b1;
        end
        if ($urandom_range(99) < 8) begin
            f = t_floor'($urandom_range(FLOORS - 1));
            cab_r[f] = 1'b0;
            up_r[f]  = 1'b0;
            dn_r[f]  = 1'b0;
        end
        if ($urandom_range(99) < 4)
            resp_r = t_floor_vec'($urandom);
        if ($urandom_range(99) < 30) begin
            if ($urandom_range(1) && int'(pos) < FLOORS - 1)
                pos = pos + 1'b1;
            else if (pos != '0)
                pos = pos - 1'b1;
        end
        req = mk(1'($urandom_range(1)), pos, cab_r, up_r, dn_r, resp_r);
    endtask

    task automatic run_traffic(input int count);
        t_in_item req;
        repeat (count) begin
            next_traffic(req);
            send_request(req);
        end
    endtask

    initial begin
        t_in_item req;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_door_ticks(2);

        send_request(mk(0, 3, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b1111, 4'b1111, 4'b1111, 4'b1111));
        send_request(mk(1, 1, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0010, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        // hall call without responsibility is no call
        send_request(mk(0, 0, 4'b0000, 4'b1000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b1000, 4'b0000, 4'b1000));
        send_request(mk(1, 2, 4'b0000, 4'b1000, 4'b0000, 4'b1000));
        send_request(mk(1, 3, 4'b0000, 4'b1000, 4'b0000, 4'b1000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        // reverse at the top, pass an up call with work still below
        send_request(mk(0, 0, 4'b0001, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(1, 2, 4'b0001, 4'b0100, 4'b0000, 4'b0100));
        send_request(mk(1, 1, 4'b0000, 4'b0010, 4'b0000, 4'b0010));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b1000, 4'b1000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        // stop at the top floor beats dropping to wait
        send_request(mk(0, 0, 4'b1000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(1, 3, 4'b1000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        drain_results();

        write_door_ticks(0);
        run_traffic(300);
        drain_results();

        write_door_ticks(1);
        steady = 1'b1;
        run_traffic(300);
        steady = 1'b0;
        drain_results();

        write_door_ticks(TICKS_W'($urandom_range(2, 12)));
        run_traffic(400);

        // let the doors close before the longest door time is set, then keep calls away
        while (sb.mode == MODE_DOORS)
            send_request(mk(0, 0, 4'b0000, 4'b0000, 4'b0000, 4'b0000));
        drain_results();
        write_door_ticks('1);
        repeat (80) begin
            req = mk(1'($urandom_range(1)), t_floor'($urandom_range(3)), 4'b0000, 4'b0000,
                     4'b0000, t_floor_vec'($urandom));
            send_request(req);
        end
        drain_results();
        repeat (4) @(posedge clk);

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ecc_pkg.sv
rtl/ecc_step.sv
rtl/elevator_car_controller_unit.sv
rtl/ecc_checker.sv
bench/tb_elevator_car_controller_unit.sv
